// File: sv/lifo_stack_with_sort_reverse_defines.svh
// Assertion helpers shared by the stack RTL.
// Both clock on clk and are switched off while arst_n is low.
`ifndef LIFO_STACK_WITH_SORT_REVERSE_DEFINES_SVH
`define LIFO_STACK_WITH_SORT_REVERSE_DEFINES_SVH

// Same-cycle implication.
`define LSR_ASSERT_HOLDS(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define LSR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/lsr_pkg.sv
package lsr_pkg;

	localparam int DEPTH  = 64;
	localparam int AW     = $clog2(DEPTH);
	localparam int CW     = $clog2(DEPTH + 1);
	localparam int DW     = 32;
	localparam int FILL_W = 7;

	localparam logic signed [DW-1:0] TOP_EMPTY = {1'b1, {(DW-1){1'b0}}};
	localparam logic signed [DW-1:0] POP_EMPTY = {DW{1'b1}};

	typedef enum logic [1:0] {
		ACT_PUSH    = 2'd0,
		ACT_POP     = 2'd1,
		ACT_REVERSE = 2'd2,
		ACT_SORT    = 2'd3
	} lsr_action_t;

	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_EMPTY = 2'd1,
		STS_FULL  = 2'd2
	} lsr_status_t;

	typedef struct packed {
		lsr_action_t             action;
		logic signed [DW-1:0]    data_in;
	} lsr_cmd_t;

	typedef struct packed {
		lsr_status_t             status;
		logic signed [DW-1:0]    popped_value;
		logic signed [DW-1:0]    top_value;
		logic                    is_empty;
		logic [FILL_W-1:0]       fill_count;
	} lsr_result_t;

	// end-of-command report from the sequencer
	typedef struct packed {
		logic                    valid;
		lsr_status_t             status;
		logic signed [DW-1:0]    popped;
		logic signed [DW-1:0]    top;
		logic [CW-1:0]           count;
	} lsr_fin_t;

	// one write and one read access to a store
	typedef struct packed {
		logic                    we;
		logic [AW-1:0]           waddr;
		logic signed [DW-1:0]    wdata;
		logic [AW-1:0]           raddr;
	} lsr_port_t;

endpackage

// File: sv/lifo_stack_with_sort_reverse.sv
// Bounded LIFO stack of signed 32-bit words, 64 entries deep.
// Command channel: a transfer happens on a rising edge with start high and
// busy low; cmd carries the action (push, pop, reverse, sort) and data_in.
// Result channel: done is high for exactly one cycle per command, with result
// holding status, popped value, new top, empty flag and fill count. The
// receiver cannot hold results off, so every result is taken as presented.
// Command flow, by action:
//   push (or refused push/pop, or reverse of fewer than two): done straight
//     from idle, busy stays low, so these may follow every cycle;
//   pop: busy high for one cycle while the new top is read;
//   reverse of n words: floor(n/2) pairs, each read low, read high, written
//     low, written high, as the stack store has one read and one write port;
//   sort of n words: each word off the stack is read, latched and compared;
//     a word moved back waits for the new scratch top unless scratch empties;
//     copying home reads, then writes; the walk always runs, even on 0 or 1 word.
// Only one command is in flight; the next is taken once busy falls.
// Reset clears the fill count and the sequencer; store contents are kept,
// and stale entries at or above the fill count never reach the result.
`include "lifo_stack_with_sort_reverse_defines.svh"

module lifo_stack_with_sort_reverse (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  lsr_pkg::lsr_cmd_t     cmd,
	output logic                  done,
	output lsr_pkg::lsr_result_t  result
);
	import lsr_pkg::*;

	lsr_fin_t             fin;
	lsr_port_t            stk_port;
	lsr_port_t            scr_port;
	logic signed [DW-1:0] stk_rdata;
	logic signed [DW-1:0] scr_rdata;

	logic                 done_q;
	lsr_result_t          result_q;

	// sequencer: owns the fill count, cached top and both store ports
	lsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.busy      (busy),
		.fin       (fin),
		.stk_port  (stk_port),
		.scr_port  (scr_port),
		.stk_rdata (stk_rdata),
		.scr_rdata (scr_rdata)
	);

	// main stack store, entry 0 is the bottom
	lsr_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_stk_ram (
		.clk   (clk),
		.we    (stk_port.we),
		.waddr (stk_port.waddr),
		.wdata (stk_port.wdata),
		.raddr (stk_port.raddr),
		.rdata (stk_rdata)
	);

	// scratch stack, only touched by sort
	lsr_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_scr_ram (
		.clk   (clk),
		.we    (scr_port.we),
		.waddr (scr_port.waddr),
		.wdata (scr_port.wdata),
		.raddr (scr_port.raddr),
		.rdata (scr_rdata)
	);

	// output register: formats the report and drives the strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fin.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fin.valid) begin
			result_q.status       <= fin.status;
			result_q.popped_value <= fin.popped;
			// cached top is stale once the stack is empty
			result_q.top_value    <= (fin.count == '0) ? TOP_EMPTY : fin.top;
			result_q.is_empty     <= (fin.count == '0);
			result_q.fill_count   <= FILL_W'(fin.count);
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`LSR_ASSERT_NEXT(a_push_one_cycle, start && !busy && cmd.action == ACT_PUSH, done,
		"push result not presented the next cycle")
	`LSR_ASSERT_HOLDS(a_empty_top, done && result.is_empty, result.top_value == TOP_EMPTY,
		"empty stack reports a top value")

endmodule

// File: sv/lsr_ram.sv
module lsr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/lsr_ctrl.sv
`include "lifo_stack_with_sort_reverse_defines.svh"

module lsr_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  lsr_pkg::lsr_cmd_t                cmd,
	output logic                             busy,
	output lsr_pkg::lsr_fin_t                fin,
	output lsr_pkg::lsr_port_t               stk_port,
	output lsr_pkg::lsr_port_t               scr_port,
	input  logic signed [lsr_pkg::DW-1:0]    stk_rdata,
	input  logic signed [lsr_pkg::DW-1:0]    scr_rdata
);
	import lsr_pkg::*;

	typedef enum logic [11:0] {
		S_IDLE    = 12'b0000_0000_0001,
		S_POPW    = 12'b0000_0000_0010,
		S_RV_RLO  = 12'b0000_0000_0100,
		S_RV_RHI  = 12'b0000_0000_1000,
		S_RV_W1   = 12'b0000_0001_0000,
		S_RV_W2   = 12'b0000_0010_0000,
		S_SO_LD   = 12'b0000_0100_0000,
		S_SO_LDW  = 12'b0000_1000_0000,
		S_SO_CMP  = 12'b0001_0000_0000,
		S_SO_STW  = 12'b0010_0000_0000,
		S_CP_RD   = 12'b0100_0000_0000,
		S_CP_WR   = 12'b1000_0000_0000
	} lsr_state_t;

	lsr_state_t           state_q, state_d;
	logic [CW-1:0]        count_q, count_d;
	logic signed [DW-1:0] top_q, top_d;
	logic signed [DW-1:0] popped_q, popped_d;
	logic [CW-1:0]        lo_q, lo_d;
	logic [CW-1:0]        hi_q, hi_d;
	logic [CW-1:0]        n_q, n_d;
	logic [CW-1:0]        t_q, t_d;
	logic signed [DW-1:0] v_q, v_d;
	logic signed [DW-1:0] st_q, st_d;
	logic signed [DW-1:0] a_q, a_d;

	logic                 fin_v;
	lsr_status_t          fin_sts;
	logic signed [DW-1:0] fin_pop;

	logic [CW-1:0]        cnt_m2, n_m1, t_m1, t_m2;

	assign cnt_m2 = count_q - CW'(2);
	assign n_m1   = n_q - CW'(1);
	assign t_m1   = t_q - CW'(1);
	assign t_m2   = t_q - CW'(2);
	assign busy   = (state_q != S_IDLE);

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		top_d    = top_q;
		popped_d = popped_q;
		lo_d     = lo_q;
		hi_d     = hi_q;
		n_d      = n_q;
		t_d      = t_q;
		v_d      = v_q;
		st_d     = st_q;
		a_d      = a_q;
		fin_v    = 1'b0;
		fin_sts  = STS_OK;
		fin_pop  = '0;
		stk_port = '0;
		scr_port = '0;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (cmd.action)
						ACT_PUSH: begin
							fin_v = 1'b1;
							if (count_q >= CW'(DEPTH)) begin
								fin_sts = STS_FULL;
							end else begin
								stk_port.we    = 1'b1;
								stk_port.waddr = count_q[AW-1:0];
								stk_port.wdata = cmd.data_in;
								count_d        = count_q + CW'(1);
								top_d          = cmd.data_in;
							end
						end
						ACT_POP: begin
							if (count_q == '0) begin
								fin_v   = 1'b1;
								fin_sts = STS_EMPTY;
								fin_pop = POP_EMPTY;
							end else begin
								// fetch the element that becomes the new top
								stk_port.raddr = cnt_m2[AW-1:0];
								popped_d       = top_q;
								count_d        = count_q - CW'(1);
								state_d        = S_POPW;
							end
						end
						ACT_REVERSE: begin
							if (count_q < CW'(2)) begin
								fin_v = 1'b1;
							end else begin
								lo_d    = '0;
								hi_d    = count_q - CW'(1);
								state_d = S_RV_RLO;
							end
						end
						ACT_SORT: begin
							n_d     = count_q;
							t_d     = '0;
							state_d = S_SO_LD;
						end
					endcase
				end
			end
			S_POPW: begin
				top_d   = stk_rdata;
				fin_v   = 1'b1;
				fin_pop = popped_q;
				state_d = S_IDLE;
			end
			S_RV_RLO: begin
				stk_port.raddr = lo_q[AW-1:0];
				state_d        = S_RV_RHI;
			end
			S_RV_RHI: begin
				stk_port.raddr = hi_q[AW-1:0];
				a_d            = stk_rdata;
				state_d        = S_RV_W1;
			end
			S_RV_W1: begin
				stk_port.we    = 1'b1;
				stk_port.waddr = lo_q[AW-1:0];
				stk_port.wdata = stk_rdata;
				// old bottom becomes the new top
				if (lo_q == '0) begin
					top_d = a_q;
				end
				state_d = S_RV_W2;
			end
			S_RV_W2: begin
				stk_port.we    = 1'b1;
				stk_port.waddr = hi_q[AW-1:0];
				stk_port.wdata = a_q;
				lo_d           = lo_q + CW'(1);
				hi_d           = hi_q - CW'(1);
				if (lo_q + CW'(2) < hi_q) begin
					state_d = S_RV_RLO;
				end else begin
					fin_v   = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_SO_LD: begin
				if (n_q == '0) begin
					lo_d    = '0;
					state_d = S_CP_RD;
				end else begin
					stk_port.raddr = n_m1[AW-1:0];
					n_d            = n_m1;
					state_d        = S_SO_LDW;
				end
			end
			S_SO_LDW: begin
				v_d     = stk_rdata;
				state_d = S_SO_CMP;
			end
			S_SO_CMP: begin
				if (t_q != '0 && st_q > v_q) begin
					// move the larger scratch top back onto the stack
					stk_port.we    = 1'b1;
					stk_port.waddr = n_q[AW-1:0];
					stk_port.wdata = st_q;
					n_d            = n_q + CW'(1);
					t_d            = t_m1;
					if (t_q >= CW'(2)) begin
						scr_port.raddr = t_m2[AW-1:0];
						state_d        = S_SO_STW;
					end
				end else begin
					scr_port.we    = 1'b1;
					scr_port.waddr = t_q[AW-1:0];
					scr_port.wdata = v_q;
					st_d           = v_q;
					t_d            = t_q + CW'(1);
					state_d        = S_SO_LD;
				end
			end
			S_SO_STW: begin
				st_d    = scr_rdata;
				state_d = S_SO_CMP;
			end
			S_CP_RD: begin
				if (lo_q == t_q) begin
					top_d   = st_q;
					fin_v   = 1'b1;
					state_d = S_IDLE;
				end else begin
					scr_port.raddr = lo_q[AW-1:0];
					state_d        = S_CP_WR;
				end
			end
			S_CP_WR: begin
				stk_port.we    = 1'b1;
				stk_port.waddr = lo_q[AW-1:0];
				stk_port.wdata = scr_rdata;
				lo_d           = lo_q + CW'(1);
				state_d        = S_CP_RD;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		fin = '{valid: fin_v, status: fin_sts, popped: fin_pop, top: top_d, count: count_d};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		top_q    <= top_d;
		popped_q <= popped_d;
		lo_q     <= lo_d;
		hi_q     <= hi_d;
		n_q      <= n_d;
		t_q      <= t_d;
		v_q      <= v_d;
		st_q     <= st_d;
		a_q      <= a_d;
	end

	`LSR_ASSERT_HOLDS(a_count_bound, 1'b1, count_q <= CW'(DEPTH), "element count beyond depth")
	`LSR_ASSERT_HOLDS(a_sort_conserve, state_q == S_SO_CMP || state_q == S_SO_STW,
		(CW+1)'(n_q) + (CW+1)'(t_q) < (CW+1)'(count_q) + (CW+1)'(1),
		"sort lost track of elements")
	`LSR_ASSERT_NEXT(a_pop_wait, !busy && start && cmd.action == ACT_POP && count_q != '0,
		state_q == S_POPW, "pop did not wait for the new top")

endmodule
